FILE: hw/rtl/frf_pkg.sv
`default_nettype none

package frf_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int SIDE_W     = 9;
  localparam int PIX_W      = 2 * SIDE_W;
  localparam int IDX_W      = PIX_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [2:0] XF_NEGATIVE  = 3'd0;
  localparam logic [2:0] XF_ROT_RIGHT = 3'd1;
  localparam logic [2:0] XF_ROT_LEFT  = 3'd2;
  localparam logic [2:0] XF_MIRROR_H  = 3'd3;
  localparam logic [2:0] XF_MIRROR_V  = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COLOR_MODE   = 3'd2;
  localparam logic [2:0] REG_MAX_VALUE    = 3'd3;
  localparam logic [2:0] REG_TRANSFORM    = 3'd4;

  typedef struct packed {
    logic [SIDE_W-1:0] image_width;
    logic [SIDE_W-1:0] image_height;
    logic              color_mode;
    logic [7:0]        max_value;
    logic [2:0]        transform;
  } frf_cfg_t;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic              rgb;
    logic              negate;
    logic [7:0]        max_value;
    logic [2:0]        xform;
  } frf_geom_t;

  typedef struct packed {
    logic              fetch;
    logic [7:0]        sample;
    logic [SIDE_W-1:0] mul_a;
    logic [SIDE_W-1:0] add_b;
    logic [1:0]        sub;
    logic              last;
  } frf_entry_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                   input int max_side);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (int'(v) > max_side) begin
      r = SIDE_W'(max_side);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/frf_div.sv
`default_nettype none

module frf_div #(
  parameter int DW = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [frf_pkg::SIDE_W-1:0] divisor,
  output logic                       done,
  output logic [DW-1:0]              quotient,
  output logic [frf_pkg::SIDE_W-1:0] remainder
);
  import frf_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]   cnt;
  logic            busy;
  logic [SIDE_W:0] trial;
  logic [SIDE_W:0] diff;
  logic            take;

  assign trial = {remainder, quotient[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      remainder <= take ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
      quotient  <= {quotient[DW-2:0], take};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frf_front.sv
`default_nettype none

module frf_front #(
  parameter int STORE_DEPTH = 196608
) (
  input  logic                  clk,
  input  logic                  rst,
  input  frf_pkg::frf_cfg_t     cfg,
  input  logic                  cfg_write,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic [0:0]            s_tuser,
  output frf_pkg::frf_geom_t    geom,
  output logic                  push,
  output frf_pkg::frf_entry_t   push_entry,
  input  logic                  fifo_full
);
  import frf_pkg::*;

  localparam int               CNT_W    = $clog2(STORE_DEPTH + 1);
  localparam int               RECIP_SH = CNT_W + 1;
  localparam logic [CNT_W-1:0] RECIP3   = CNT_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);

  typedef enum logic [5:0] {
    ST_RUN   = 6'b000001,
    ST_LATCH = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_TOT   = 6'b001000,
    ST_DIVA  = 6'b010000,
    ST_DIVB  = 6'b100000
  } state_t;

  state_t             st;
  state_t             st_next;
  logic [CNT_W-1:0]   load_count;
  logic [CNT_W-1:0]   emit_count;
  logic [CNT_W-1:0]   emit_inc;
  logic [CNT_W-1:0]   total;
  logic [PIX_W-1:0]   wh;
  logic [IDX_W-1:0]   full_size;
  logic [1:0]         kk;
  logic [SIDE_W-1:0]  col;
  logic [SIDE_W-1:0]  row;
  logic [SIDE_W-1:0]  out_w;
  logic [SIDE_W-1:0]  wm1;
  logic [SIDE_W-1:0]  hm1;
  logic [SIDE_W-1:0]  mul_a;
  logic [SIDE_W-1:0]  add_b;
  logic               accept;
  logic               is_fetch;
  logic               can_load;
  logic               can_fetch;
  logic               pix_last;
  logic               col_last;
  logic [2*CNT_W-1:0] third_prod;
  logic [CNT_W-1:0]   third;
  logic [CNT_W-1:0]   pix_pos;
  logic               div_start;
  logic               div_done;
  logic [CNT_W-1:0]   div_dividend;
  logic [SIDE_W-1:0]  div_divisor;
  logic [CNT_W-1:0]   div_quo;
  logic [SIDE_W-1:0]  div_rem;

  frf_div #(.DW(CNT_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign s_tready  = (st == ST_RUN) && !fifo_full;
  assign accept    = s_tvalid && s_tready;
  assign is_fetch  = s_tuser[0] == OP_FETCH;
  assign can_load  = load_count < total;
  assign can_fetch = !can_load && (emit_count < total);
  assign push      = accept && (is_fetch ? can_fetch : can_load);
  assign emit_inc  = emit_count + CNT_W'(1);

  assign out_w    = (geom.xform == XF_ROT_RIGHT || geom.xform == XF_ROT_LEFT) ?
                    geom.height : geom.width;
  assign wm1      = geom.width - SIDE_W'(1);
  assign hm1      = geom.height - SIDE_W'(1);
  assign pix_last = !geom.rgb || (kk == 2'd2);
  assign col_last = col == (out_w - SIDE_W'(1));
  assign full_size = geom.rgb ? (IDX_W'(wh) + (IDX_W'(wh) << 1)) : IDX_W'(wh);

  // Pixel number of an RGB sample count, by multiplying with the reciprocal of three.
  assign third_prod = (2*CNT_W)'(emit_count) * (2*CNT_W)'(RECIP3);
  assign third      = CNT_W'(third_prod >> RECIP_SH);

  // Operands of the source address: address = mul_a * width + add_b.
  always_comb begin
    unique case (geom.xform)
      XF_ROT_RIGHT: begin
        mul_a = hm1 - col;
        add_b = row;
      end
      XF_ROT_LEFT: begin
        mul_a = col;
        add_b = wm1 - row;
      end
      XF_MIRROR_H: begin
        mul_a = row;
        add_b = wm1 - col;
      end
      XF_MIRROR_V: begin
        mul_a = hm1 - row;
        add_b = col;
      end
      default: begin
        mul_a = row;
        add_b = col;
      end
    endcase
  end

  always_comb begin
    push_entry.fetch  = is_fetch;
    push_entry.sample = s_tdata;
    push_entry.mul_a  = mul_a;
    push_entry.add_b  = add_b;
    push_entry.sub    = kk;
    push_entry.last   = emit_inc == total;
  end

  assign div_start    = st == ST_DIVA;
  assign div_dividend = pix_pos;
  assign div_divisor  = out_w;

  always_comb begin
    unique case (st)
      ST_RUN:   st_next = ST_RUN;
      ST_LATCH: st_next = ST_MUL;
      ST_MUL:   st_next = ST_TOT;
      ST_TOT:   st_next = ST_DIVA;
      ST_DIVA:  st_next = ST_DIVB;
      ST_DIVB:  st_next = div_done ? ST_RUN : ST_DIVB;
      default:  st_next = ST_LATCH;
    endcase
    if (cfg_write) begin
      st_next = ST_LATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_LATCH;
      load_count <= '0;
      emit_count <= '0;
      kk         <= '0;
      col        <= '0;
      row        <= '0;
    end else begin
      st <= st_next;
      if (accept && !is_fetch && can_load) begin
        load_count <= load_count + CNT_W'(1);
      end
      if (accept && is_fetch && can_fetch) begin
        emit_count <= emit_inc;
        if (pix_last) begin
          kk <= '0;
          if (col_last) begin
            col <= '0;
            row <= row + SIDE_W'(1);
          end else begin
            col <= col + SIDE_W'(1);
          end
        end else begin
          kk <= kk + 2'd1;
        end
      end
      if (st == ST_TOT) begin
        kk <= geom.rgb ? 2'(emit_count - (third + (third << 1))) : 2'd0;
      end
      if ((st == ST_DIVB) && div_done) begin
        col <= div_rem;
        row <= SIDE_W'(div_quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_LATCH) begin
      geom.width     <= clamp_side(cfg.image_width, MAX_SIDE);
      geom.height    <= clamp_side(cfg.image_height, MAX_SIDE);
      geom.rgb       <= cfg.color_mode;
      geom.negate    <= cfg.transform == XF_NEGATIVE;
      geom.max_value <= cfg.max_value;
      geom.xform     <= cfg.transform;
    end
    if (st == ST_MUL) begin
      wh <= PIX_W'(geom.width) * PIX_W'(geom.height);
    end
    if (st == ST_TOT) begin
      total   <= (int'(full_size) > STORE_DEPTH) ? CNT_W'(STORE_DEPTH) : CNT_W'(full_size);
      pix_pos <= geom.rgb ? third : emit_count;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frf_fifo.sv
`default_nettype none

module frf_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  frf_pkg::frf_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output frf_pkg::frf_entry_t pop_entry,
  output logic                empty
);
  import frf_pkg::*;

  frf_entry_t         slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full      = count == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frf_back.sv
`default_nettype none

module frf_back #(
  parameter int STORE_DEPTH = 196608
) (
  input  logic                clk,
  input  logic                rst,
  input  frf_pkg::frf_geom_t  geom,
  input  logic                fifo_empty,
  input  frf_pkg::frf_entry_t pop_entry,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import frf_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int XW     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  logic [7:0]        mem [STORE_DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic              adv;

  logic              v1;
  logic              fetch1;
  logic [7:0]        sample1;
  logic [PIX_W-1:0]  prod1;
  logic [SIDE_W-1:0] b1;
  logic [1:0]        sub1;
  logic              last1;

  logic              v2;
  logic              fetch2;
  logic [7:0]        sample2;
  logic [PIX_W-1:0]  pix2;
  logic [1:0]        sub2;
  logic              last2;
  logic [IDX_W-1:0]  idx2;
  logic [XW-1:0]     idx_x;
  logic              oob2;
  logic [ADDR_W-1:0] rd_addr;

  logic              v3;
  logic              last3;
  logic              oob3;
  logic [7:0]        rd_data;
  logic [7:0]        src3;

  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !fifo_empty;

  assign idx2 = geom.rgb ?
                (IDX_W'(pix2) + (IDX_W'(pix2) << 1) + IDX_W'(sub2)) : IDX_W'(pix2);
  assign idx_x   = XW'(idx2);
  assign oob2    = idx_x >= XW'(STORE_DEPTH);
  assign rd_addr = idx_x[ADDR_W-1:0];
  assign src3    = oob3 ? 8'd0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
      wr_ptr   <= '0;
    end else if (adv) begin
      v1       <= !fifo_empty;
      v2       <= v1;
      v3       <= v2 && fetch2;
      m_tvalid <= v3;
      if (v2 && !fetch2) begin
        wr_ptr <= wr_ptr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fetch1  <= pop_entry.fetch;
      sample1 <= pop_entry.sample;
      prod1   <= PIX_W'(pop_entry.mul_a) * PIX_W'(geom.width);
      b1      <= pop_entry.add_b;
      sub1    <= pop_entry.sub;
      last1   <= pop_entry.last;
      fetch2  <= fetch1;
      sample2 <= sample1;
      pix2    <= prod1 + PIX_W'(b1);
      sub2    <= sub1;
      last2   <= last1;
      last3   <= last2;
      oob3    <= oob2;
      m_tdata <= geom.negate ? (geom.max_value - src3) : src3;
      m_tlast <= last3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      if (!fetch2) begin
        mem[wr_ptr] <= sample2;
      end else if (!oob2) begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frame_rotate_flip_invert.sv
// A fetch item passes the FIFO and the multiply, address and read stages to m_tdata.
// Loads and fetches are taken at one item per cycle while the output is not stalled.
// After reset and after each register write the block recomputes its frame size and
// read position with one serial division and holds off input until it is done.
// Reset is synchronous and active high; it clears the counters and registers,
// but not the frame store, and a new frame starts only after a reset.
`default_nettype none

module frame_rotate_flip_invert #(
  parameter int STORE_DEPTH = 196608
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // sample_in[7:0]
  input  logic [0:0]  s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // sample_out[7:0]
  output logic        m_tlast
);
  import frf_pkg::*;

  frf_cfg_t   cfg;
  frf_geom_t  geom;
  frf_entry_t push_entry;
  frf_entry_t pop_entry;
  logic       cfg_write;
  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= SIDE_W'(256);
      cfg.image_height <= SIDE_W'(256);
      cfg.color_mode   <= 1'b0;
      cfg.max_value    <= 8'd255;
      cfg.transform    <= XF_NEGATIVE;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[SIDE_W-1:0];
        REG_COLOR_MODE:   cfg.color_mode   <= pwdata[0];
        REG_MAX_VALUE:    cfg.max_value    <= pwdata[7:0];
        REG_TRANSFORM:    cfg.transform    <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IMAGE_WIDTH:  prdata = 32'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg.image_height);
      REG_COLOR_MODE:   prdata = 32'(cfg.color_mode);
      REG_MAX_VALUE:    prdata = 32'(cfg.max_value);
      REG_TRANSFORM:    prdata = 32'(cfg.transform);
      default:          prdata = '0;
    endcase
  end

  frf_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_write  (cfg_write),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .geom       (geom),
    .push       (push),
    .push_entry (push_entry),
    .fifo_full  (fifo_full)
  );

  frf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (fifo_empty)
  );

  frf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .fifo_empty (fifo_empty),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/frf_checker.sv
`default_nettype none

module frf_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        pready,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // A result that waits must keep its sample and its frame marker.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // A register write starts the setup pass, so no item is taken in the next cycle.
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=> !s_tready)
    else $error("item taken right after a register write");

  // Reset empties the output and holds off the input side.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("block not idle after reset");

  // No result can appear in the cycle right after reset.
  a_no_result_from_reset: assert property (@(posedge clk)
    $rose(m_tvalid) |-> !$past(rst))
    else $error("result appeared straight out of reset");

endmodule

bind frame_rotate_flip_invert frf_checker u_frf_checker (.*);

`default_nettype wire

FILE: verif/frame_rotate_flip_invert_checker.sv
`timescale 1ns / 100ps

module frame_rotate_flip_invert_checker #(
  parameter int MAX_SIDE    = 256,
  parameter int STORE_DEPTH = 196608
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // sample_in[7:0]
  input  logic [0:0]  s_tuser,   // op[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // sample_out[7:0]
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          loaded,
  output int          emitted,
  output int          frame_total
);

  import frf_pkg::*;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } out_sample_t;

  logic [7:0]  pix_store [STORE_DEPTH];
  out_sample_t expected_samples [$];

  logic [SIDE_W-1:0] width_r;
  logic [SIDE_W-1:0] height_r;
  logic              rgb_r;
  logic [7:0]        maxv_r;
  logic [2:0]        xf_r;

  int          load_cnt;
  int          emit_cnt;
  int          mismatches;
  int          result_idx;
  int          total_now;
  logic [7:0]  pix;
  out_sample_t want;
  out_sample_t got;

  function automatic int side_of(input logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int samples_in_frame();
    longint n;
    n = longint'(side_of(width_r)) * side_of(height_r);
    if (rgb_r) n = n * 3;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return int'(n);
  endfunction

  // Store address of output sample number e under the current geometry.
  function automatic int source_addr(input int e);
    int w, h, ps, k, p, r, c, src;
    w  = side_of(width_r);
    h  = side_of(height_r);
    ps = rgb_r ? 3 : 1;
    k  = e % ps;
    p  = e / ps;
    case (xf_r)
      XF_ROT_RIGHT: begin
        r = p / h;
        c = p % h;
        src = r + (h - 1 - c) * w;
      end
      XF_ROT_LEFT: begin
        r = p / h;
        c = p % h;
        src = (w - 1 - r) + c * w;
      end
      XF_MIRROR_H: begin
        r = p / w;
        c = p % w;
        src = r * w + (w - 1 - c);
      end
      XF_MIRROR_V: begin
        r = p / w;
        c = p % w;
        src = (h - 1 - r) * w + c;
      end
      default: begin
        src = p;
      end
    endcase
    return src * ps + k;
  endfunction

  task automatic note_mismatch(input string what, input out_sample_t exp_s,
                               input out_sample_t got_s);
    if (mismatches < 10) begin
      $display("checker: result %0d %s: expected sample %02h last %0b, got sample %02h last %0b",
               result_idx, what, exp_s.sample, exp_s.last, got_s.sample, got_s.last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_r  = SIDE_W'(256);
      height_r = SIDE_W'(256);
      rgb_r    = 1'b0;
      maxv_r   = 8'hFF;
      xf_r     = XF_NEGATIVE;
      load_cnt = 0;
      emit_cnt = 0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_IMAGE_WIDTH:  width_r  = pwdata[SIDE_W-1:0];
          REG_IMAGE_HEIGHT: height_r = pwdata[SIDE_W-1:0];
          REG_COLOR_MODE:   rgb_r    = pwdata[0];
          REG_MAX_VALUE:    maxv_r   = pwdata[7:0];
          REG_TRANSFORM:    xf_r     = pwdata[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        total_now = samples_in_frame();
        if (s_tuser[0] == OP_LOAD) begin
          if (load_cnt < total_now) begin
            pix_store[load_cnt] = s_tdata;
            load_cnt++;
          end
        end else if (load_cnt >= total_now && emit_cnt < total_now) begin
          pix = pix_store[source_addr(emit_cnt)];
          if (xf_r == XF_NEGATIVE) pix = maxv_r - pix;
          emit_cnt++;
          want.sample = pix;
          want.last   = (emit_cnt == total_now);
          expected_samples.push_back(want);
        end
      end
      if (m_tvalid && m_tready) begin
        got.sample = m_tdata;
        got.last   = m_tlast;
        if (expected_samples.size() == 0) begin
          want = '0;
          note_mismatch("arrived with nothing expected", want, got);
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample || got.last !== want.last) begin
            note_mismatch("differs", want, got);
          end
        end
        result_idx++;
      end
    end
    errors      <= mismatches;
    pending     <= expected_samples.size();
    loaded      <= load_cnt;
    emitted     <= emit_cnt;
    frame_total <= samples_in_frame();
  end

endmodule

FILE: verif/frame_rotate_flip_invert_tb.sv
`timescale 1ns / 100ps

module frame_rotate_flip_invert_tb;

  import frf_pkg::*;

  localparam int STORE_DEPTH   = 196608;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 48;

  typedef enum {RUN_FULL, RUN_HALF_FETCH, RUN_HALF_LOAD} run_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // sample_in[7:0]
  logic [0:0]  s_tuser  = '0;   // op[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // sample_out[7:0]
  logic        m_tlast;

  int chk_errors;
  int chk_pending;
  int chk_loaded;
  int chk_emitted;
  int chk_total;

  int burst_left;
  int stall_hold;
  int stall_mode;
  int cycle_cnt;

  always #6 clk = ~clk;

  frame_rotate_flip_invert #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  frame_rotate_flip_invert_checker #(
    .MAX_SIDE    (MAX_SIDE),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .errors      (chk_errors),
    .pending     (chk_pending),
    .loaded      (chk_loaded),
    .emitted     (chk_emitted),
    .frame_total (chk_total)
  );

  // The receiver switches between free flow, light, heavy and near-total stalling.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(8, 96);
    end
    stall_hold--;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("frame_rotate_flip_invert_tb: errors");
    $finish;
  end

  task automatic send_item(input logic op, input logic [7:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_phase(input int n_load, input int n_fetch, input int noise_pct);
    while (n_load > 0 || n_fetch > 0) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end else if (n_load > 0) begin
        send_item(OP_LOAD, 8'($urandom));
        n_load--;
      end else begin
        send_item(OP_FETCH, 8'($urandom));
        n_fetch--;
      end
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_frame(input logic [31:0] w, input logic [31:0] h, input logic rgb,
                           input logic [7:0] maxv, input logic [2:0] xf);
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_COLOR_MODE, {31'd0, rgb});
    reg_write(REG_MAX_VALUE, {24'd0, maxv});
    reg_write(REG_TRANSFORM, {29'd0, xf});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // A side of one pixel may also be written as zero, a full side as any larger value.
  function automatic logic [31:0] side_code(input int s);
    logic [31:0] code;
    code = s;
    if (s == 1 && $urandom_range(0, 2) == 0) begin
      code = 0;
    end else if (s == MAX_SIDE && $urandom_range(0, 1) == 0) begin
      code = $urandom_range(MAX_SIDE + 1, 511);
    end
    return code;
  endfunction

  task automatic grow_phase(input int w, input int h, input logic rgb, input logic [7:0] maxv,
                            input logic [2:0] xf, input run_mode_t mode);
    int n_load;
    int n_fetch;
    set_frame(side_code(w), side_code(h), rgb, maxv, xf);
    n_load  = (chk_total > chk_loaded) ? chk_total - chk_loaded : 0;
    n_fetch = (chk_total > chk_emitted) ? chk_total - chk_emitted : 0;
    if (mode == RUN_HALF_LOAD) begin
      n_load  = n_load / 2;
      n_fetch = 0;
    end else if (mode == RUN_HALF_FETCH) begin
      n_fetch = n_fetch / 2;
    end
    run_phase(n_load, n_fetch, 8);
    settle();
  endtask

  initial begin
    int          kind;
    int          goal;
    int          w;
    int          h;
    int          ps;
    int          swap;
    int          phase_no;
    logic        rgb;
    logic [2:0]  xf;
    logic [7:0]  maxv;

    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    settle();

    // Fetches before any load, at the reset geometry.
    send_item(OP_FETCH, 8'h00);
    send_item(OP_FETCH, 8'hFF);
    settle();

    set_frame(2, 2, 1'b0, 8'hFF, XF_NEGATIVE);
    send_item(OP_FETCH, 8'h00);
    send_item(OP_LOAD, 8'h00);
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'h5A);
    send_item(OP_LOAD, 8'hA5);
    send_item(OP_LOAD, 8'h11);
    repeat (4) send_item(OP_FETCH, 8'hFF);
    send_item(OP_FETCH, 8'h00);
    settle();

    // Samples above the maximum make the negative wrap around.
    set_frame(3, 2, 1'b0, 8'h10, XF_NEGATIVE);
    send_item(OP_LOAD, 8'h80);
    send_item(OP_LOAD, 8'h7F);
    repeat (2) send_item(OP_FETCH, 8'h00);
    settle();

    set_frame(3, 3, 1'b0, 8'hFF, XF_ROT_RIGHT);
    send_item(OP_LOAD, 8'h01);
    send_item(OP_LOAD, 8'h02);
    send_item(OP_LOAD, 8'h03);
    repeat (3) send_item(OP_FETCH, 8'h00);
    settle();

    phase_no = 0;
    while (chk_loaded < 300) begin
      kind = $urandom_range(0, 9);
      rgb  = 1'($urandom_range(0, 1));
      xf   = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7)) : 3'(phase_no % 5);
      case ($urandom_range(0, 4))
        0:       maxv = 8'h00;
        1:       maxv = 8'hFF;
        2:       maxv = 8'h01;
        default: maxv = 8'($urandom);
      endcase
      if (kind < 2) begin
        set_frame(side_code($urandom_range(1, 6)), side_code($urandom_range(1, 6)), rgb, maxv,
                  xf);
        run_phase($urandom_range(1, 8), $urandom_range(1, 8), 40);
        settle();
      end else begin
        ps   = rgb ? 3 : 1;
        goal = chk_loaded + $urandom_range(3, 30);
        w    = $urandom_range(1, 16);
        h    = (goal + w * ps - 1) / (w * ps);
        if (h > MAX_SIDE) begin
          h = MAX_SIDE;
          w = (goal + MAX_SIDE * ps - 1) / (MAX_SIDE * ps);
        end
        if ($urandom_range(0, 1) == 1) begin
          swap = w;
          w    = h;
          h    = swap;
        end
        grow_phase(w, h, rgb, maxv, xf,
                   (kind == 2) ? RUN_HALF_FETCH : (kind == 3) ? RUN_HALF_LOAD : RUN_FULL);
      end
      phase_no++;
    end

    // Full-side frames, each read out partly under one geometry and finished under the other.
    grow_phase(MAX_SIDE, 2, 1'b0, 8'hFF, XF_ROT_RIGHT, RUN_HALF_FETCH);
    grow_phase(2, MAX_SIDE, 1'b0, 8'h00, XF_ROT_LEFT, RUN_FULL);
    grow_phase(MAX_SIDE, 1, 1'b1, 8'h80, XF_MIRROR_H, RUN_HALF_FETCH);
    grow_phase(1, MAX_SIDE, 1'b1, 8'h01, XF_MIRROR_V, RUN_FULL);

    if (chk_errors == 0) begin
      $display("frame_rotate_flip_invert_tb: clean");
    end else begin
      $display("frame_rotate_flip_invert_tb: errors");
    end
    $finish;
  end

endmodule
